// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules of this project.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle, ignored while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ebc_pkg.sv =====
// Package of the epoch seconds to BCD calendar converter.
// Holds the sequencer state type, control and status structs, constants and helpers.
`timescale 1ns / 1ps

package ebc_pkg;

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;
   localparam logic [31:0] DAYS_LEAP     = 32'd366;
   localparam logic [31:0] DAYS_COMMON   = 32'd365;
   localparam logic [11:0] BASE_YEAR     = 12'd1970;
   localparam logic [11:0] CENTURY_BASE  = 12'd2000;
   localparam logic [11:0] CENTURY_LAST  = 12'd2099;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [3:0]  FEBRUARY      = 4'd1;

   // Residues of the base year, used to track the leap year rule.
   localparam logic [1:0]  BASE_MOD4     = 2'd2;
   localparam logic [6:0]  BASE_MOD100   = 7'd70;
   localparam logic [8:0]  BASE_MOD400   = 9'd370;

   // Step counts of the three restoring divisions, minus one.
   localparam logic [3:0]  DAY_STEPS     = 4'd15;
   localparam logic [3:0]  HOUR_STEPS    = 4'd4;
   localparam logic [3:0]  MIN_STEPS     = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAY,
      ST_HOUR,
      ST_MIN,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      state_type  state;
      logic [3:0] step;
   } ctrl_type;

   typedef struct packed {
      logic borrow;
      logic mon_last;
   } status_type;

   // Length of a month, index 0 for January.
   function automatic logic [31:0] month_len(input logic [3:0] mon, input logic leap);
      logic [31:0] len;
      case (mon)
         FEBRUARY: begin
            len = leap ? 32'd29 : 32'd28;
         end
         4'd3, 4'd5, 4'd8, 4'd10: begin
            len = 32'd30;
         end
         default: begin
            len = 32'd31;
         end
      endcase
      return len;
   endfunction

   // Two BCD digits of a value below 100, tens taken by a reciprocal multiply.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

// ===== rtl/epoch_seconds_to_bcd_calendar.sv =====
// One item at a time: 16 day-division steps, 5 hour steps, 6 minute steps, then one step per
// year and per month, all through the single shared subtractor. busy is high meanwhile.
// The result strobe lasts one cycle and cannot be held off. Synchronous reset clears the
// sequencer and the strobe; the result registers keep their contents.
// Top level of the epoch seconds to BCD calendar converter; uses ebc_pkg, ebc_seq, ebc_sub.
`timescale 1ns / 1ps

module epoch_seconds_to_bcd_calendar
   import ebc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [6:0]  rsp_seconds_bcd,
   output logic [6:0]  rsp_minutes_bcd,
   output logic [5:0]  rsp_hours_bcd,
   output logic [6:0]  rsp_weekday_mask,
   output logic [5:0]  rsp_day_bcd,
   output logic [4:0]  rsp_month_bcd,
   output logic [7:0]  rsp_year_bcd,
   output logic        rsp_out_of_range
);

   ctrl_type   ctrl;
   status_type status;

   logic [31:0] operand;
   logic [31:0] diff;
   logic        borrow;
   logic        qbit;
   logic        leap;

   logic [31:0] rem_ff, rem_in;
   logic [15:0] day_ff, day_in;
   logic [4:0]  hr_ff, hr_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [2:0]  wd_ff, wd_in;
   logic [11:0] yr_ff, yr_in;
   logic [1:0]  c4_ff, c4_in;
   logic [6:0]  c100_ff, c100_in;
   logic [8:0]  c400_ff, c400_in;
   logic [3:0]  mon_ff, mon_in;

   logic        valid_ff, valid_in;
   logic [6:0]  sec_bcd_ff, sec_bcd_in;
   logic [6:0]  min_bcd_ff, min_bcd_in;
   logic [5:0]  hr_bcd_ff, hr_bcd_in;
   logic [6:0]  mask_ff, mask_in;
   logic [5:0]  dom_bcd_ff, dom_bcd_in;
   logic [4:0]  mon_bcd_ff, mon_bcd_in;
   logic [7:0]  yr_bcd_ff, yr_bcd_in;
   logic        oor_ff, oor_in;

   logic [3:0]  wd_step;
   logic [3:0]  wd_final;
   logic        bad_year;
   logic [31:0] step_rem;

   ebc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl)
   );

   ebc_sub u_sub (
      .a      (rem_ff),
      .b      (operand),
      .diff   (diff),
      .borrow (borrow)
   );

   assign busy            = (ctrl.state != ST_IDLE);
   assign qbit            = !borrow;
   assign leap            = (c400_ff == 9'd0) || ((c4_ff == 2'd0) && (c100_ff != 7'd0));
   assign status.borrow   = borrow;
   assign status.mon_last = (mon_ff == LAST_MONTH);
   assign step_rem        = qbit ? diff : rem_ff;

   // Operand of the shared subtractor for the current step.
   always_comb begin
      case (ctrl.state)
         ST_DAY:   operand = SECS_PER_DAY << ctrl.step;
         ST_HOUR:  operand = SECS_PER_HOUR << ctrl.step;
         ST_MIN:   operand = SECS_PER_MIN << ctrl.step;
         ST_YEAR:  operand = leap ? DAYS_LEAP : DAYS_COMMON;
         ST_MONTH: operand = month_len(mon_ff, leap);
         default:  operand = 32'd0;
      endcase
   end

   // Weekday residue: fold each new quotient bit of the day count into a value mod 7.
   always_comb begin
      wd_step = {wd_ff, 1'b0} + {3'd0, qbit};
      if (wd_step >= 4'd7) begin
         wd_step = wd_step - 4'd7;
      end
      wd_final = {1'b0, wd_ff} + 4'd4;
      if (wd_final >= 4'd7) begin
         wd_final = wd_final - 4'd7;
      end
   end

   assign bad_year = (yr_ff < CENTURY_BASE) || (yr_ff > CENTURY_LAST);

   // Next values of the working registers and of the result registers.
   always_comb begin
      rem_in     = rem_ff;
      day_in     = day_ff;
      hr_in      = hr_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      wd_in      = wd_ff;
      yr_in      = yr_ff;
      c4_in      = c4_ff;
      c100_in    = c100_ff;
      c400_in    = c400_ff;
      mon_in     = mon_ff;
      valid_in   = 1'b0;
      sec_bcd_in = sec_bcd_ff;
      min_bcd_in = min_bcd_ff;
      hr_bcd_in  = hr_bcd_ff;
      mask_in    = mask_ff;
      dom_bcd_in = dom_bcd_ff;
      mon_bcd_in = mon_bcd_ff;
      yr_bcd_in  = yr_bcd_ff;
      oor_in     = oor_ff;
      case (ctrl.state)
         ST_IDLE: begin
            if (start) begin
               rem_in  = req_epoch_seconds;
               day_in  = 16'd0;
               hr_in   = 5'd0;
               min_in  = 6'd0;
               wd_in   = 3'd0;
               yr_in   = BASE_YEAR;
               c4_in   = BASE_MOD4;
               c100_in = BASE_MOD100;
               c400_in = BASE_MOD400;
               mon_in  = 4'd0;
            end
         end
         ST_DAY: begin
            rem_in = step_rem;
            day_in = {day_ff[14:0], qbit};
            wd_in  = wd_step[2:0];
         end
         ST_HOUR: begin
            rem_in = step_rem;
            hr_in  = {hr_ff[3:0], qbit};
         end
         ST_MIN: begin
            min_in = {min_ff[4:0], qbit};
            if (ctrl.step == 4'd0) begin
               // Minute remainder is the second; the day count moves in for the walks.
               sec_in = step_rem[5:0];
               rem_in = {16'd0, day_ff};
            end else begin
               rem_in = step_rem;
            end
         end
         ST_YEAR: begin
            if (qbit) begin
               rem_in  = diff;
               yr_in   = yr_ff + 12'd1;
               c4_in   = c4_ff + 2'd1;
               c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            end
         end
         ST_MONTH: begin
            if (!status.mon_last && qbit) begin
               rem_in = diff;
               mon_in = mon_ff + 4'd1;
            end
         end
         ST_DONE: begin
            valid_in   = 1'b1;
            sec_bcd_in = 7'(to_bcd({1'b0, sec_ff}));
            min_bcd_in = 7'(to_bcd({1'b0, min_ff}));
            hr_bcd_in  = 6'(to_bcd({2'd0, hr_ff}));
            mask_in    = 7'd1 << wd_final[2:0];
            dom_bcd_in = 6'(to_bcd(7'(rem_ff[4:0]) + 7'd1));
            mon_bcd_in = 5'(to_bcd(7'(mon_ff) + 7'd1));
            yr_bcd_in  = bad_year ? 8'd0 : to_bcd(7'(yr_ff - CENTURY_BASE));
            oor_in     = bad_year;
         end
         default: begin
         end
      endcase
   end

   // Control register: the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      day_ff     <= day_in;
      hr_ff      <= hr_in;
      min_ff     <= min_in;
      sec_ff     <= sec_in;
      wd_ff      <= wd_in;
      yr_ff      <= yr_in;
      c4_ff      <= c4_in;
      c100_ff    <= c100_in;
      c400_ff    <= c400_in;
      mon_ff     <= mon_in;
      sec_bcd_ff <= sec_bcd_in;
      min_bcd_ff <= min_bcd_in;
      hr_bcd_ff  <= hr_bcd_in;
      mask_ff    <= mask_in;
      dom_bcd_ff <= dom_bcd_in;
      mon_bcd_ff <= mon_bcd_in;
      yr_bcd_ff  <= yr_bcd_in;
      oor_ff     <= oor_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_seconds_bcd  = sec_bcd_ff;
   assign rsp_minutes_bcd  = min_bcd_ff;
   assign rsp_hours_bcd    = hr_bcd_ff;
   assign rsp_weekday_mask = mask_ff;
   assign rsp_day_bcd      = dom_bcd_ff;
   assign rsp_month_bcd    = mon_bcd_ff;
   assign rsp_year_bcd     = yr_bcd_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

// ===== rtl/ebc_sub.sv =====
// Shared compare and subtract unit of the calendar converter.
// Every division step and every year or month walk step goes through it.
`timescale 1ns / 1ps

module ebc_sub
   import ebc_pkg::*;
(
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] diff,
   output logic        borrow
);

   logic [32:0] wide;

   // A borrow means a is below b.
   assign wide   = {1'b0, a} - {1'b0, b};
   assign diff   = wide[31:0];
   assign borrow = wide[32];

endmodule

// ===== rtl/ebc_seq.sv =====
// Sequencer of the calendar converter.
// Steps through the divisions and the year and month walks; uses ebc_pkg.
`timescale 1ns / 1ps

module ebc_seq
   import ebc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;

   // State and step registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state: fixed-length divisions; walks stop on a borrow or in December.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DAY;
               step_in  = DAY_STEPS;
            end
         end
         ST_DAY: begin
            if (step_ff == 4'd0) begin
               state_in = ST_HOUR;
               step_in  = HOUR_STEPS;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_HOUR: begin
            if (step_ff == 4'd0) begin
               state_in = ST_MIN;
               step_in  = MIN_STEPS;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_MIN: begin
            if (step_ff == 4'd0) begin
               state_in = ST_YEAR;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_YEAR: begin
            if (status.borrow) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (status.mon_last || status.borrow) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ctrl.state = state_ff;
   assign ctrl.step  = step_ff;

endmodule

// ===== rtl/ebc_checker.sv =====
// Port-level checker of the calendar converter, bound to the top level.
// Uses the macros of assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ebc_checker
   import ebc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [6:0] rsp_weekday_mask,
   input logic [7:0] rsp_year_bcd,
   input logic       rsp_out_of_range
);

   // An accepted transfer makes the block busy in the next cycle.
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy did not rise after start")

   // The result strobe comes only once the block has finished its work.
   `ASSERT_SAME(a_valid_idle, clock, reset, rsp_valid, !busy, "result shown while busy")

   // One result per item: the strobe lasts a single cycle.
   `ASSERT_NEXT(a_valid_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe held")

   // The weekday has exactly one bit set.
   `ASSERT_SAME(a_wd_onehot, clock, reset, rsp_valid, $onehot(rsp_weekday_mask), "weekday not one-hot")

   // An out-of-range year forces the year byte to zero.
   `ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_year_bcd == 8'd0, "year not cleared")

endmodule

bind epoch_seconds_to_bcd_calendar ebc_checker u_ebc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_weekday_mask (rsp_weekday_mask),
   .rsp_year_bcd     (rsp_year_bcd),
   .rsp_out_of_range (rsp_out_of_range)
);

// ===== test/epoch_seconds_to_bcd_calendar_test.sv =====
// Self-checking testbench of the epoch seconds to BCD calendar converter.
// Drives epoch_seconds_to_bcd_calendar directly; needs only the RTL and its package.
`timescale 1ns / 1ps

module epoch_seconds_to_bcd_calendar_test;

   localparam int unsigned SECS_IN_DAY    = 86400;
   localparam int unsigned SECS_IN_HOUR   = 3600;
   localparam int unsigned FIRST_YEAR     = 1970;
   localparam int unsigned CENTURY_FIRST  = 2000;
   localparam int unsigned CENTURY_FINAL  = 2099;
   localparam int unsigned CENTURY_START  = 32'd946684800;   // 2000-01-01 00:00:00
   localparam int unsigned CENTURY_END    = 32'd4102444799;  // 2099-12-31 23:59:59
   localparam int unsigned LAST_WHOLE_DAY = 49709;
   localparam int unsigned RANDOM_ITEMS   = 1300;
   localparam int unsigned DRAIN_CYCLES   = 200;
   localparam int unsigned MAX_REPORTS    = 10;

   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct {
      logic [31:0] epoch;
      logic [6:0]  seconds_bcd;
      logic [6:0]  minutes_bcd;
      logic [5:0]  hours_bcd;
      logic [6:0]  weekday_mask;
      logic [5:0]  day_bcd;
      logic [4:0]  month_code;
      logic [7:0]  year_code;
      logic        out_of_range;
   } calendar_regs_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_epoch_seconds;
   logic        rsp_valid;
   logic [6:0]  rsp_seconds_bcd;
   logic [6:0]  rsp_minutes_bcd;
   logic [5:0]  rsp_hours_bcd;
   logic [6:0]  rsp_weekday_mask;
   logic [5:0]  rsp_day_bcd;
   logic [4:0]  rsp_month_bcd;
   logic [7:0]  rsp_year_bcd;
   logic        rsp_out_of_range;

   calendar_regs_type pending_dates [$];
   int unsigned       mismatch_count = 0;

   epoch_seconds_to_bcd_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_seconds_bcd   (rsp_seconds_bcd),
      .rsp_minutes_bcd   (rsp_minutes_bcd),
      .rsp_hours_bcd     (rsp_hours_bcd),
      .rsp_weekday_mask  (rsp_weekday_mask),
      .rsp_day_bcd       (rsp_day_bcd),
      .rsp_month_bcd     (rsp_month_bcd),
      .rsp_year_bcd      (rsp_year_bcd),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gregorian rule: every fourth year, except centuries not divisible by 400.
   function automatic logic is_leap(input int unsigned year);
      return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
   endfunction

   // Two decimal digits, tens in the high nibble.
   function automatic logic [7:0] bcd2(input int unsigned value);
      return {4'((value / 10) % 10), 4'(value % 10)};
   endfunction

   // Calendar registers that one epoch count should produce.
   function automatic calendar_regs_type calendar_of(input logic [31:0] epoch);
      int unsigned       days;
      int unsigned       day_secs;
      int unsigned       left;
      int unsigned       year;
      int unsigned       month;
      int unsigned       month_len;
      logic              beyond;
      calendar_regs_type regs;
      days     = epoch / SECS_IN_DAY;
      day_secs = epoch % SECS_IN_DAY;
      left     = days;
      year     = FIRST_YEAR;
      // Strip whole years, then whole months of the year found.
      while (left >= (is_leap(year) ? 366 : 365)) begin
         left -= is_leap(year) ? 366 : 365;
         year++;
      end
      month = 0;
      while (month < 11) begin
         month_len = DAYS_IN_MONTH[month];
         if (month == 1 && is_leap(year)) begin
            month_len = 29;
         end
         if (left < month_len) begin
            break;
         end
         left -= month_len;
         month++;
      end
      beyond             = (year < CENTURY_FIRST) || (year > CENTURY_FINAL);
      regs.epoch         = epoch;
      regs.seconds_bcd   = 7'(bcd2(day_secs % 60));
      regs.minutes_bcd   = 7'(bcd2((day_secs % SECS_IN_HOUR) / 60));
      regs.hours_bcd     = 6'(bcd2(day_secs / SECS_IN_HOUR));
      // Day zero was a Thursday; bit 0 of the mask is Sunday.
      regs.weekday_mask  = 7'(1 << ((days + 4) % 7));
      regs.day_bcd       = 6'(bcd2(left + 1));
      regs.month_code    = 5'(bcd2(month + 1));
      regs.year_code     = beyond ? 8'h00 : bcd2(year - CENTURY_FIRST);
      regs.out_of_range  = beyond;
      return regs;
   endfunction

   // Random epoch counts, weighted toward this century and toward day edges.
   function automatic logic [31:0] random_epoch();
      int unsigned day;
      int unsigned mode;
      logic [31:0] epoch;
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         epoch = $urandom();
      end else if (mode < 7) begin
         epoch = $urandom_range(CENTURY_END, CENTURY_START);
      end else begin
         day   = $urandom_range(0, LAST_WHOLE_DAY);
         epoch = day * SECS_IN_DAY;
         if ($urandom_range(0, 1) == 1) begin
            epoch += SECS_IN_DAY - 1 - $urandom_range(0, 3);
         end else begin
            epoch += $urandom_range(0, 3);
         end
      end
      return epoch;
   endfunction

   // Idle gap before the next transfer; at least a quarter of the items go back to back.
   function automatic int unsigned random_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got, input logic [31:0] epoch);
      if (want != got) begin
         note_failure($sformatf("%s for epoch %0d: expected %0h, got %0h",
                                name, epoch, want, got));
      end
   endtask

   // Hold start low for the gap, then present the item until the block takes it.
   task automatic send_epoch(input logic [31:0] epoch, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start             <= 1'b0;
         req_epoch_seconds <= $urandom();
      end
      @(negedge clock);
      start             <= 1'b1;
      req_epoch_seconds <= epoch;
      while (busy !== 1'b0) begin
         @(negedge clock);
      end
      @(posedge clock);
      pending_dates.push_back(calendar_of(epoch));
   endtask

   // Every result strobe is compared with the oldest pending conversion.
   always @(posedge clock) begin
      calendar_regs_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_dates.size() == 0) begin
            note_failure("result strobe with no conversion pending");
         end else begin
            want = pending_dates.pop_front();
            check_field("seconds", want.seconds_bcd, rsp_seconds_bcd, want.epoch);
            check_field("minutes", want.minutes_bcd, rsp_minutes_bcd, want.epoch);
            check_field("hours", want.hours_bcd, rsp_hours_bcd, want.epoch);
            check_field("weekday", want.weekday_mask, rsp_weekday_mask, want.epoch);
            check_field("day", want.day_bcd, rsp_day_bcd, want.epoch);
            check_field("month", want.month_code, rsp_month_bcd, want.epoch);
            check_field("year", want.year_code, rsp_year_bcd, want.epoch);
            check_field("out_of_range", want.out_of_range, rsp_out_of_range, want.epoch);
         end
      end
   end

   // Ends of the input range, alternating bit patterns and the year 2038 rollover.
   task automatic test_field_extremes();
      send_epoch(32'd0, 0);             // Thursday 1970-01-01, below the century
      send_epoch(32'hFFFF_FFFF, 0);     // largest count, a Sunday in 2106
      send_epoch(32'h7FFF_FFFF, 3);
      send_epoch(32'h8000_0000, 0);
      send_epoch(32'hAAAA_AAAA, 0);
      send_epoch(32'h5555_5555, 5);
      send_epoch(32'd86399, 0);         // last second of the first day
      send_epoch(32'd86400, 0);
   endtask

   // Century edges and each branch of the leap year rule.
   task automatic test_leap_and_century();
      send_epoch(32'd946684799, 0);     // 1999-12-31 23:59:59, just below the century
      send_epoch(32'd946684800, 0);     // 2000-01-01, first year in range
      send_epoch(32'd951782400, 2);     // 2000-02-29, leap by the 400 rule
      send_epoch(32'd951868800, 0);     // 2000-03-01
      send_epoch(32'd978307199, 0);     // 2000-12-31, day 366
      send_epoch(32'd68169600, 0);      // 1972-02-29, out of range leap day
      send_epoch(32'd1704067199, 1);    // 2023-12-31 23:59:59
      send_epoch(32'd1709164800, 0);    // 2024-02-29
      send_epoch(32'd1709251199, 0);    // last second of that leap day
      send_epoch(32'd4102444799, 0);    // 2099-12-31 23:59:59, last in range
      send_epoch(32'd4102444800, 0);    // 2100-01-01, above the century
      send_epoch(32'd4107456000, 4);    // 2100-02-28, century year not leap
      send_epoch(32'd4107542400, 0);    // 2100-03-01
   endtask

   // Random counts with random gaps, and a burst with no gaps every hundred items.
   task automatic test_random_dates();
      for (int unsigned item = 0; item < RANDOM_ITEMS; item++) begin
         send_epoch(random_epoch(), (item % 100 < 20) ? 0 : random_gap());
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_epoch_seconds = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_leap_and_century();
      test_random_dates();

      @(negedge clock);
      start <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (pending_dates.size() != 0) begin
         note_failure($sformatf("no result for epoch %0d", pending_dates[0].epoch));
         void'(pending_dates.pop_front());
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
